/* rtl/core/ihg_pkg.sv */
// Shared constants and types for the IPv4 header generator.
package ihg_pkg;

  localparam int unsigned MAX_FRAME = 1600;
  localparam int unsigned HDR_BYTES = 20;
  localparam int unsigned NUM_WORDS = 5;

  localparam logic [7:0]  VER_IHL    = 8'h45;
  localparam logic [7:0]  TTL_VALUE  = 8'd64;
  localparam logic [15:0] IDENT_INIT = 16'd1;
  localparam logic [2:0]  LAST_INDEX = 3'(NUM_WORDS - 1);

  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned IN_DATA_W  = 56;

  typedef enum logic [1:0] {
    CFG_LOCAL_ADDRESS   = 2'd0,
    CFG_SUBNET_MASK     = 2'd1,
    CFG_GATEWAY_ADDRESS = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [NUM_WORDS-1:0][31:0] words;
    logic [31:0]                next_hop;
    logic                       is_broadcast;
    logic                       rejected;
  } hdr_t;

endpackage

/* rtl/core/ipv4_header_generator.sv */
// Top level of the IPv4 header generator: request register, header buffer and word output.
// Each request waits in an input register until the output buffer can take it; its
// whole header is then built in a single pass and loaded into the output buffer, from
// which five 32-bit words leave in network order, the fifth marked by tlast. A request
// too long for the frame gives one transfer with tuser set. The output channel sets the
// rate: rejected requests leave one per cycle while m_axis_tready is high, and each
// request passes the input register and then the output buffer before its first word.
// The next request is taken into the input register while the current header is still
// being sent. Configuration writes must be made while no request is in flight.
module ipv4_header_generator
  import ihg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // dest_address[31:0], protocol_number[39:32], payload_length[55:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // header_word[31:0], word_index[34:32], next_hop[66:35], is_broadcast[67], zeros above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // rejected
  output logic                  m_axis_tuser
);

  logic [31:0] local_address;
  logic [31:0] subnet_mask;
  logic [31:0] gateway_address;
  logic [15:0] ident;

  logic                 req_valid;
  logic [IN_DATA_W-1:0] req_data;
  logic                 out_valid;
  hdr_t                 out_hdr;
  logic [2:0]           word_index;
  hdr_t                 built;
  logic                 load;
  logic                 out_last;
  logic [31:0]          cur_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address   <= '0;
      subnet_mask     <= '0;
      gateway_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS:   local_address   <= cfg_data;
        CFG_SUBNET_MASK:     subnet_mask     <= cfg_data;
        CFG_GATEWAY_ADDRESS: gateway_address <= cfg_data;
        default: ;
      endcase
    end
  end

  ihg_build u_build (
    .dest_address    (req_data[31:0]),
    .protocol_number (req_data[39:32]),
    .payload_length  (req_data[55:40]),
    .ident           (ident),
    .local_address   (local_address),
    .subnet_mask     (subnet_mask),
    .gateway_address (gateway_address),
    .hdr             (built)
  );

  assign out_last      = out_hdr.rejected || word_index == LAST_INDEX;
  assign load          = req_valid && (!out_valid || (m_axis_tready && out_last));
  assign s_axis_tready = !req_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      req_valid <= 1'b1;
    end else if (load) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_data <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident <= IDENT_INIT;
    end else if (load && !built.rejected) begin
      ident <= ident + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      word_index <= '0;
    end else if (load) begin
      out_valid  <= 1'b1;
      word_index <= '0;
    end else if (out_valid && m_axis_tready) begin
      if (out_last) begin
        out_valid <= 1'b0;
      end
      word_index <= word_index + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hdr <= built;
    end
  end

  always_comb begin
    case (word_index)
      3'd0:    cur_word = out_hdr.words[0];
      3'd1:    cur_word = out_hdr.words[1];
      3'd2:    cur_word = out_hdr.words[2];
      3'd3:    cur_word = out_hdr.words[3];
      3'd4:    cur_word = out_hdr.words[4];
      default: cur_word = '0;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_hdr.is_broadcast, out_hdr.next_hop,
                          (out_hdr.rejected ? 3'd0 : word_index), cur_word};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_hdr.rejected;

endmodule

/* rtl/core/ihg_build.sv */
// Header construction: length check, checksum and next-hop selection for one request.
module ihg_build
  import ihg_pkg::*;
(
  input  logic [31:0] dest_address,
  input  logic [7:0]  protocol_number,
  input  logic [15:0] payload_length,
  input  logic [15:0] ident,
  input  logic [31:0] local_address,
  input  logic [31:0] subnet_mask,
  input  logic [31:0] gateway_address,
  output hdr_t        hdr
);

  logic [16:0] total;
  logic        too_long;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] checksum;
  logic        bcast;
  logic [31:0] hop;
  logic        off_subnet;

  assign total    = 17'(payload_length) + 17'(HDR_BYTES);
  assign too_long = total > 17'(MAX_FRAME);

  assign sum = 20'({VER_IHL, 8'h00}) + 20'(total[15:0]) + 20'(ident)
             + 20'({TTL_VALUE, protocol_number})
             + 20'(local_address[31:16]) + 20'(local_address[15:0])
             + 20'(dest_address[31:16]) + 20'(dest_address[15:0]);
  assign fold1    = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2    = fold1[15:0] + 16'(fold1[16]);
  assign checksum = ~fold2;

  assign bcast      = dest_address == 32'hFFFF_FFFF;
  assign off_subnet = ((dest_address ^ local_address) & subnet_mask) != 32'd0;

  always_comb begin
    if (bcast || !off_subnet || gateway_address == 32'd0) begin
      hop = dest_address;
    end else begin
      hop = gateway_address;
    end
  end

  always_comb begin
    if (too_long) begin
      hdr = '0;
      hdr.rejected = 1'b1;
    end else begin
      hdr.words[0]     = {VER_IHL, 8'h00, total[15:0]};
      hdr.words[1]     = {ident, 16'h0000};
      hdr.words[2]     = {TTL_VALUE, protocol_number, checksum};
      hdr.words[3]     = local_address;
      hdr.words[4]     = dest_address;
      hdr.next_hop     = hop;
      hdr.is_broadcast = bcast;
      hdr.rejected     = 1'b0;
    end
  end

endmodule

/* rtl/core/ihg_checker.sv */
// Port-level assertions for the IPv4 header generator and their bind.
module ihg_checker
  import ihg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("Output changed while stalled.");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("Rejected transfer is not a single empty last transfer.");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast == (m_axis_tdata[34:32] == LAST_INDEX))
    else $error("tlast does not match the final header word.");

  a_next: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("Header words are not sent in sequence.");

endmodule

bind ipv4_header_generator ihg_checker u_ihg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
